/* hw/rtl/vdm_pkg.sv */
`timescale 1ns / 1ps

package vdm_pkg;

  localparam int VAL_W      = 24;
  localparam int DIFF_W     = VAL_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ACC_W      = 56;
  localparam int FRAC_W     = 16;
  localparam int MAN_SHIFT  = 8;
  localparam int DIST_W     = 40;
  localparam int CNT_W      = 7;
  localparam int CNT_LIMIT  = 127;
  localparam int METRIC_W   = 2;
  localparam int ROOT_W     = (ACC_W + FRAC_W) / 2;
  localparam int RAD_W      = ACC_W + FRAC_W;
  localparam int REM_W      = ROOT_W + 4;
  localparam int QUO_W      = FRAC_W + 1;
  localparam int DIV_STEPS  = QUO_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(ROOT_STEPS);

  localparam int MAX_ELEMENTS_DEF = 64;

  typedef enum logic {
    MODE_DIV,
    MODE_ROOT
  } iter_mode_t;

  typedef struct packed {
    logic              go;
    iter_mode_t        mode;
    logic [DIFF_W-1:0] dividend;
    logic [DIFF_W-1:0] divisor;
    logic [ACC_W-1:0]  radicand;
  } iter_cmd_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } iter_resp_t;

endpackage

/* hw/rtl/vdm_iter.sv */
`timescale 1ns / 1ps

module vdm_iter (
  input  logic                 clk,
  input  logic                 rst,
  input  vdm_pkg::iter_cmd_t   cmd,
  output vdm_pkg::iter_resp_t  resp
);
  import vdm_pkg::*;

  logic              running;
  logic              done;
  iter_mode_t        mode;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] acc;
  logic [RAD_W-1:0]  src;
  logic [DIFF_W-1:0] divisor;

  logic [REM_W-1:0]  cand;
  logic [REM_W-1:0]  trial;
  logic [REM_W-1:0]  diff;
  logic              borrow;
  logic              ge;
  logic [STEP_W-1:0] last_step;

  // shared compare and subtract step
  always_comb begin
    if (mode == MODE_DIV) begin
      cand      = (cnt == '0) ? rem : {rem[REM_W-2:0], 1'b0};
      trial     = {{(REM_W-DIFF_W){1'b0}}, divisor};
      last_step = STEP_W'(DIV_STEPS - 1);
    end else begin
      cand      = {rem[REM_W-3:0], src[RAD_W-1 -: 2]};
      trial     = {{(REM_W-ROOT_W-2){1'b0}}, acc, 2'b01};
      last_step = STEP_W'(ROOT_STEPS - 1);
    end
    {borrow, diff} = {1'b0, cand} - {1'b0, trial};
    ge = !borrow;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        running <= 1'b1;
        mode    <= cmd.mode;
        cnt     <= '0;
        acc     <= '0;
        rem     <= (cmd.mode == MODE_DIV) ? {{(REM_W-DIFF_W){1'b0}}, cmd.dividend} : '0;
        src     <= {cmd.radicand, {FRAC_W{1'b0}}};
        divisor <= cmd.divisor;
      end else if (running) begin
        rem <= ge ? diff : cand;
        acc <= {acc[ROOT_W-2:0], ge};
        src <= {src[RAD_W-3:0], 2'b00};
        cnt <= cnt + 1'b1;
        if (cnt == last_step) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign resp.done   = done;
  assign resp.result = acc;

endmodule

/* hw/rtl/vector_distance_metrics_top.sv */
`timescale 1ns / 1ps
// steps per element: prep, term, add and finish for euclidean and manhattan; a pair that adds
// no term skips add; canberra waits for the 17-step shared divider before add, and a
// euclidean last element then runs the 36-step root; done rises in the same cycle busy falls
// elements are taken one at a time, only while idle; no overlap
// reset: synchronous active-high rst clears sequencer, sum, count and metric
// the receiver cannot stall: done marks distance and terms_counted for one cycle
module vector_distance_metrics_top #(
  parameter int MAX_ELEMENTS = vdm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [vdm_pkg::VAL_W-1:0] value_a,
  input  logic signed [vdm_pkg::VAL_W-1:0] value_b,
  input  logic                          a_missing,
  input  logic                          b_missing,
  input  logic                          last_element,
  input  logic                          metric_we,
  input  logic [vdm_pkg::METRIC_W-1:0]  metric_data,
  output logic                          done,
  output logic [vdm_pkg::DIST_W-1:0]    distance,
  output logic [vdm_pkg::CNT_W-1:0]     terms_counted
);
  import vdm_pkg::*;

  localparam logic [METRIC_W-1:0] METRIC_EUCLID    = 2'd0;
  localparam logic [METRIC_W-1:0] METRIC_MANHATTAN = 2'd1;
  localparam logic [METRIC_W-1:0] METRIC_CANBERRA  = 2'd2;
  localparam logic [METRIC_W-1:0] METRIC_BAD       = 2'd3;
  localparam int CNT_CAP_I = (MAX_ELEMENTS < CNT_LIMIT) ? MAX_ELEMENTS : CNT_LIMIT;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_TERM,
    S_WAIT,
    S_ADD,
    S_FINISH,
    S_ROOT
  } state_t;

  state_t                     state;
  logic [METRIC_W-1:0]        metric_select;
  logic signed [VAL_W-1:0]    a_r;
  logic signed [VAL_W-1:0]    b_r;
  logic                       skip_r;
  logic                       last_r;
  logic [DIFF_W-1:0]          d_r;
  logic [DIFF_W-1:0]          den_r;
  logic [ACC_W-1:0]           term_r;
  logic [ACC_W-1:0]           sum;
  logic [CNT_W-1:0]           count;

  logic signed [DIFF_W-1:0]   diff_s;
  logic [DIFF_W-1:0]          d_next;
  logic [VAL_W-1:0]           mag_a;
  logic [VAL_W-1:0]           mag_b;
  logic [DIFF_W-1:0]          den_next;
  logic [PROD_W-1:0]          prod;
  logic [ACC_W:0]             sum_ext;
  logic [DIST_W-1:0]          sum_sat;
  iter_cmd_t                  iter_cmd;
  iter_resp_t                 iter_resp;

  assign busy = (state != S_IDLE);

  assign diff_s   = DIFF_W'(a_r) - DIFF_W'(b_r);
  assign d_next   = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);
  assign mag_a    = a_r[VAL_W-1] ? VAL_W'(-a_r) : VAL_W'(a_r);
  assign mag_b    = b_r[VAL_W-1] ? VAL_W'(-b_r) : VAL_W'(b_r);
  assign den_next = {1'b0, mag_a} + {1'b0, mag_b};
  assign prod     = d_r * d_r;
  assign sum_ext  = {1'b0, sum} + {1'b0, term_r};
  assign sum_sat  = (|sum[ACC_W-1:DIST_W]) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];

  always_comb begin
    iter_cmd          = '0;
    iter_cmd.dividend = d_r;
    iter_cmd.divisor  = den_r;
    iter_cmd.radicand = sum;
    iter_cmd.mode     = MODE_DIV;
    if (state == S_TERM && !skip_r && metric_select == METRIC_CANBERRA
        && den_r != '0) begin
      iter_cmd.go = 1'b1;
    end
    if (state == S_FINISH && last_r && metric_select == METRIC_EUCLID) begin
      iter_cmd.go   = 1'b1;
      iter_cmd.mode = MODE_ROOT;
    end
  end

  vdm_iter u_iter (
    .clk  (clk),
    .rst  (rst),
    .cmd  (iter_cmd),
    .resp (iter_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_select <= METRIC_EUCLID;
    end else if (metric_we && metric_data != METRIC_BAD) begin
      metric_select <= metric_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      sum   <= '0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            a_r    <= value_a;
            b_r    <= value_b;
            skip_r <= a_missing | b_missing;
            last_r <= last_element;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          d_r   <= d_next;
          den_r <= den_next;
          state <= S_TERM;
        end
        S_TERM: begin
          if (skip_r) begin
            state <= S_FINISH;
          end else begin
            case (metric_select)
              METRIC_EUCLID: begin
                term_r <= ACC_W'(prod);
                state  <= S_ADD;
              end
              METRIC_MANHATTAN: begin
                term_r <= ACC_W'({d_r, {MAN_SHIFT{1'b0}}});
                state  <= S_ADD;
              end
              default: begin
                state <= (den_r == '0) ? S_FINISH : S_WAIT;
              end
            endcase
          end
        end
        S_WAIT: begin
          if (iter_resp.done) begin
            term_r <= ACC_W'(iter_resp.result[QUO_W-1:0]);
            state  <= S_ADD;
          end
        end
        S_ADD: begin
          sum   <= sum_ext[ACC_W] ? {ACC_W{1'b1}} : sum_ext[ACC_W-1:0];
          if (count < CNT_CAP) begin
            count <= count + 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!last_r) begin
            state <= S_IDLE;
          end else if (metric_select == METRIC_EUCLID) begin
            state <= S_ROOT;
          end else begin
            done          <= 1'b1;
            distance      <= sum_sat;
            terms_counted <= count;
            sum           <= '0;
            count         <= '0;
            state         <= S_IDLE;
          end
        end
        S_ROOT: begin
          if (iter_resp.done) begin
            done          <= 1'b1;
            distance      <= DIST_W'(iter_resp.result);
            terms_counted <= count;
            sum           <= '0;
            count         <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (terms_counted <= CNT_CAP))
    else $error("term count beyond cap");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    done |-> (sum == '0 && count == '0))
    else $error("sum or count not cleared after result");
`endif

endmodule
